/* hdl/tbh_pkg.sv */
`timescale 1ns / 1ps

package tbh_pkg;

   // default field widths
   localparam int COORD_BITS_DEF  = 24;
   localparam int HEIGHT_BITS_DEF = 24;

endpackage

/* hdl/tbh_req_if.sv */
`timescale 1ns / 1ps

interface tbh_req_if #(
   parameter int COORD_BITS  = tbh_pkg::COORD_BITS_DEF,
   parameter int HEIGHT_BITS = tbh_pkg::HEIGHT_BITS_DEF
);
   logic                          valid;
   logic                          ready;
   logic signed [COORD_BITS-1:0]  point_x;
   logic signed [COORD_BITS-1:0]  point_y;
   logic signed [COORD_BITS-1:0]  vertex_a_x;
   logic signed [COORD_BITS-1:0]  vertex_a_y;
   logic signed [COORD_BITS-1:0]  vertex_b_x;
   logic signed [COORD_BITS-1:0]  vertex_b_y;
   logic signed [COORD_BITS-1:0]  vertex_c_x;
   logic signed [COORD_BITS-1:0]  vertex_c_y;
   logic signed [HEIGHT_BITS-1:0] height_a;
   logic signed [HEIGHT_BITS-1:0] height_b;
   logic signed [HEIGHT_BITS-1:0] height_c;

   modport source (
      output valid, point_x, point_y, vertex_a_x, vertex_a_y, vertex_b_x, vertex_b_y,
             vertex_c_x, vertex_c_y, height_a, height_b, height_c,
      input  ready
   );
   modport sink (
      input  valid, point_x, point_y, vertex_a_x, vertex_a_y, vertex_b_x, vertex_b_y,
             vertex_c_x, vertex_c_y, height_a, height_b, height_c,
      output ready
   );
endinterface

/* hdl/tbh_rsp_if.sv */
`timescale 1ns / 1ps

interface tbh_rsp_if #(
   parameter int HEIGHT_BITS = tbh_pkg::HEIGHT_BITS_DEF
);
   logic                          valid;
   logic                          ready;
   logic                          hit;
   logic signed [HEIGHT_BITS-1:0] height_out;

   modport source (output valid, hit, height_out, input ready);
   modport sink   (input valid, hit, height_out, output ready);
endinterface

/* hdl/tbh_udiv.sv */
`timescale 1ns / 1ps

// pipelined restoring divider, one quotient bit per stage
module tbh_udiv #(
   parameter int N      = 80,
   parameter int Q      = 24,
   parameter int SIDE_W = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [N-1:0]      num,
   input  logic [N-1:0]      den,
   input  logic [SIDE_W-1:0] side_in,
   output logic              out_valid,
   output logic [Q-1:0]      quo,
   output logic [SIDE_W-1:0] side_out
);
   localparam int DW = N + Q;

   logic              valid_ff [1:Q];
   logic [N-1:0]      rem_ff   [1:Q];
   logic [N-1:0]      den_ff   [1:Q];
   logic [Q-1:0]      quo_ff   [1:Q];
   logic [SIDE_W-1:0] side_ff  [1:Q];

   for (genvar k = 0; k < Q; k++) begin : g_stage
      localparam int SH = Q - 1 - k;
      logic              v_prev;
      logic [N-1:0]      rem_prev;
      logic [N-1:0]      den_prev;
      logic [Q-1:0]      quo_prev;
      logic [SIDE_W-1:0] side_prev;
      logic [DW-1:0]     dsh;
      logic              take;
      logic [N-1:0]      rem_in;
      logic [Q-1:0]      quo_in;

      if (k == 0) begin : g_first
         assign v_prev    = in_valid;
         assign rem_prev  = num;
         assign den_prev  = den;
         assign quo_prev  = '0;
         assign side_prev = side_in;
      end else begin : g_next
         assign v_prev    = valid_ff[k];
         assign rem_prev  = rem_ff[k];
         assign den_prev  = den_ff[k];
         assign quo_prev  = quo_ff[k];
         assign side_prev = side_ff[k];
      end

      assign dsh    = DW'(den_prev) << SH;
      assign take   = DW'(rem_prev) >= dsh;
      assign rem_in = take ? N'(DW'(rem_prev) - dsh) : rem_prev;
      always_comb begin
         quo_in     = quo_prev;
         quo_in[SH] = take;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k+1] <= 1'b0;
         end else if (en) begin
            valid_ff[k+1] <= v_prev;
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k+1]  <= rem_in;
            den_ff[k+1]  <= den_prev;
            quo_ff[k+1]  <= quo_in;
            side_ff[k+1] <= side_prev;
         end
      end
   end

   assign out_valid = valid_ff[Q];
   assign quo       = quo_ff[Q];
   assign side_out  = side_ff[Q];
endmodule

/* hdl/triangle_barycentric_height.sv */
`timescale 1ns / 1ps

// Channel | Dir | Handshake    | Payload
// req_bus | in  | valid/ready  | point, vertices A B C, heights A B C
// rsp_bus | out | valid/ready  | hit, height_out
//
// One item per cycle while rsp_bus is not stalled. Items pass through the
// stage registers, one-bit-per-stage quotient pipeline, output register.
// Synchronous active-high reset clears only the valid bits.
// When a result waits untaken the whole pipeline holds; nothing is lost.
module triangle_barycentric_height #(
   parameter int COORD_BITS  = tbh_pkg::COORD_BITS_DEF,
   parameter int HEIGHT_BITS = tbh_pkg::HEIGHT_BITS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   tbh_req_if.sink   req_bus,
   tbh_rsp_if.source rsp_bus
);
   localparam int C  = COORD_BITS;
   localparam int H  = HEIGHT_BITS;
   localparam int D  = C + 1;           // coordinate difference
   localparam int X  = 2 * D + 3;       // det, na, nb, ng
   localparam int L  = X / 2;           // low split of weights
   localparam int XH = X - L;           // high split
   localparam int S  = X + H + 2;       // weighted sum
   localparam int SW = H + 3;           // divider sideband

   // global advance: the output register is free or being emptied
   logic en;
   logic rsp_valid_ff;
   assign en            = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready = en;

   function automatic logic sign_ok(logic signed [X-1:0] v, logic dneg);
      return (v == '0) || (v[X-1] == dneg);
   endfunction

   // ---- stage 1: differences, vertex match -------------------------------
   logic                v1_ff;
   logic signed [D-1:0] byc_ff, cxb_ff, axc_ff, ayc_ff, pxc_ff, pyc_ff, cya_ff;
   logic signed [H-1:0] ha1_ff, hb1_ff, hc1_ff, vh1_ff;
   logic                vm1_ff;
   logic signed [H-1:0] vh_in;
   logic                vm_in;

   always_comb begin
      vm_in = 1'b1;
      priority if (req_bus.point_x == req_bus.vertex_a_x &&
                   req_bus.point_y == req_bus.vertex_a_y) begin
         vh_in = req_bus.height_a;
      end else if (req_bus.point_x == req_bus.vertex_b_x &&
                   req_bus.point_y == req_bus.vertex_b_y) begin
         vh_in = req_bus.height_b;
      end else if (req_bus.point_x == req_bus.vertex_c_x &&
                   req_bus.point_y == req_bus.vertex_c_y) begin
         vh_in = req_bus.height_c;
      end else begin
         vm_in = 1'b0;
         vh_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         byc_ff <= D'(req_bus.vertex_b_y) - D'(req_bus.vertex_c_y);
         cxb_ff <= D'(req_bus.vertex_c_x) - D'(req_bus.vertex_b_x);
         axc_ff <= D'(req_bus.vertex_a_x) - D'(req_bus.vertex_c_x);
         ayc_ff <= D'(req_bus.vertex_a_y) - D'(req_bus.vertex_c_y);
         pxc_ff <= D'(req_bus.point_x) - D'(req_bus.vertex_c_x);
         pyc_ff <= D'(req_bus.point_y) - D'(req_bus.vertex_c_y);
         cya_ff <= D'(req_bus.vertex_c_y) - D'(req_bus.vertex_a_y);
         ha1_ff <= req_bus.height_a;
         hb1_ff <= req_bus.height_b;
         hc1_ff <= req_bus.height_c;
         vh1_ff <= vh_in;
         vm1_ff <= vm_in;
      end
   end

   // ---- stage 2: the six cross products ----------------------------------
   logic                  v2_ff;
   logic signed [2*D-1:0] pd0_ff, pd1_ff, pa0_ff, pa1_ff, pb0_ff, pb1_ff;
   logic signed [H-1:0]   ha2_ff, hb2_ff, hc2_ff, vh2_ff;
   logic                  vm2_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         pd0_ff <= byc_ff * axc_ff;
         pd1_ff <= cxb_ff * ayc_ff;
         pa0_ff <= byc_ff * pxc_ff;
         pa1_ff <= cxb_ff * pyc_ff;
         pb0_ff <= cya_ff * pxc_ff;
         pb1_ff <= axc_ff * pyc_ff;
         ha2_ff <= ha1_ff;
         hb2_ff <= hb1_ff;
         hc2_ff <= hc1_ff;
         vh2_ff <= vh1_ff;
         vm2_ff <= vm1_ff;
      end
   end

   // ---- stage 3: determinant and numerators ------------------------------
   logic                v3_ff;
   logic signed [X-1:0] det3_ff, na3_ff, nb3_ff;
   logic signed [H-1:0] ha3_ff, hb3_ff, hc3_ff, vh3_ff;
   logic                vm3_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         det3_ff <= X'(pd0_ff) + X'(pd1_ff);
         na3_ff  <= X'(pa0_ff) + X'(pa1_ff);
         nb3_ff  <= X'(pb0_ff) + X'(pb1_ff);
         ha3_ff  <= ha2_ff;
         hb3_ff  <= hb2_ff;
         hc3_ff  <= hc2_ff;
         vh3_ff  <= vh2_ff;
         vm3_ff  <= vm2_ff;
      end
   end

   // ---- stage 4: third numerator, inside test -----------------------------
   logic                v4_ff;
   logic signed [X-1:0] det4_ff, na4_ff, nb4_ff, ng4_ff;
   logic signed [H-1:0] ha4_ff, hb4_ff, hc4_ff, vh4_ff;
   logic                vm4_ff;
   logic signed [X-1:0] ng_in;

   assign ng_in = det3_ff - na3_ff - nb3_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         det4_ff <= det3_ff;
         na4_ff  <= na3_ff;
         nb4_ff  <= nb3_ff;
         ng4_ff  <= ng_in;
         ha4_ff  <= ha3_ff;
         hb4_ff  <= hb3_ff;
         hc4_ff  <= hc3_ff;
         vh4_ff  <= vh3_ff;
         vm4_ff  <= vm3_ff;
      end
   end

   logic in4;
   assign in4 = (det4_ff != '0) && sign_ok(na4_ff, det4_ff[X-1]) &&
                sign_ok(nb4_ff, det4_ff[X-1]) && sign_ok(ng4_ff, det4_ff[X-1]);

   // ---- stage 5: split weight x height partial products -------------------
   // each weight = signed high part * 2^L + unsigned low part
   logic                     v5_ff;
   logic signed [L+H:0]      lo_a_ff, lo_b_ff, lo_g_ff;
   logic signed [XH+H-1:0]   hi_a_ff, hi_b_ff, hi_g_ff;
   logic signed [X-1:0]      det5_ff;
   logic signed [H-1:0]      vh5_ff;
   logic                     vm5_ff, in5_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         lo_a_ff <= $signed({1'b0, na4_ff[L-1:0]}) * ha4_ff;
         lo_b_ff <= $signed({1'b0, nb4_ff[L-1:0]}) * hb4_ff;
         lo_g_ff <= $signed({1'b0, ng4_ff[L-1:0]}) * hc4_ff;
         hi_a_ff <= $signed(na4_ff[X-1:L]) * ha4_ff;
         hi_b_ff <= $signed(nb4_ff[X-1:L]) * hb4_ff;
         hi_g_ff <= $signed(ng4_ff[X-1:L]) * hc4_ff;
         det5_ff <= det4_ff;
         vh5_ff  <= vh4_ff;
         vm5_ff  <= vm4_ff;
         in5_ff  <= in4;
      end
   end

   // ---- stage 6: weighted sum ----------------------------------------------
   logic                v6_ff;
   logic signed [S-1:0] sum6_ff, sum_in;
   logic signed [X-1:0] det6_ff;
   logic signed [H-1:0] vh6_ff;
   logic                vm6_ff, in6_ff;

   assign sum_in = (S'(hi_a_ff) <<< L) + S'(lo_a_ff) +
                   (S'(hi_b_ff) <<< L) + S'(lo_b_ff) +
                   (S'(hi_g_ff) <<< L) + S'(lo_g_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         sum6_ff <= sum_in;
         det6_ff <= det5_ff;
         vh6_ff  <= vh5_ff;
         vm6_ff  <= vm5_ff;
         in6_ff  <= in5_ff;
      end
   end

   // ---- stage 7: magnitudes for the divider -------------------------------
   logic         v7_ff;
   logic [S-1:0] num7_ff, den7_ff;
   logic [SW-1:0] side7_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         num7_ff  <= sum6_ff[S-1] ? S'(-sum6_ff) : S'(sum6_ff);
         den7_ff  <= det6_ff[X-1] ? S'(-det6_ff) : S'(det6_ff);
         side7_ff <= {vm6_ff, in6_ff, sum6_ff[S-1] ^ det6_ff[X-1], vh6_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_bus.valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
         v7_ff <= v6_ff;
      end
   end

   // ---- quotient pipeline ---------------------------------------------------
   logic          dv_valid;
   logic [H-1:0]  quo;
   logic [SW-1:0] side_q;

   tbh_udiv #(
      .N      (S),
      .Q      (H),
      .SIDE_W (SW)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v7_ff),
      .num       (num7_ff),
      .den       (den7_ff),
      .side_in   (side7_ff),
      .out_valid (dv_valid),
      .quo       (quo),
      .side_out  (side_q)
   );

   // ---- output register: vertex hit first, then interior, else miss --------
   logic                hit_ff, hit_in;
   logic signed [H-1:0] height_ff, height_in;

   always_comb begin
      hit_in = side_q[H+2] || side_q[H+1];
      priority if (side_q[H+2]) begin
         height_in = side_q[H-1:0];
      end else if (side_q[H+1]) begin
         height_in = side_q[H] ? -$signed(quo) : $signed(quo);
      end else begin
         height_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= dv_valid;
      end
   end
   always_ff @(posedge clock) begin
      if (en) begin
         hit_ff    <= hit_in;
         height_ff <= height_in;
      end
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.hit        = hit_ff;
   assign rsp_bus.height_out = height_ff;

`ifndef SYNTH
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && !rsp_bus.hit |-> rsp_bus.height_out == '0)
      else $error("miss with nonzero height");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      req_bus.ready == (!rsp_bus.valid || rsp_bus.ready))
      else $error("input ready out of step with output stall");
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_bus.valid && !v1_ff)
      else $error("pipeline not empty after reset");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(v7_ff) && $stable(num7_ff))
      else $error("stage moved during stall");
`endif
endmodule
